/* sv/mixed_radix_profile_index_unit_assert.svh */
// Assertion macros for the mixed-radix profile index unit.
// Included by the top level; relies on nothing else.
`ifndef MIXED_RADIX_PROFILE_INDEX_UNIT_ASSERT_SVH
`define MIXED_RADIX_PROFILE_INDEX_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define MRPI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MRPI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/mrpi_pkg.sv */
// Shared types, constants and the mixed-radix doubling step.
// No dependencies; imported by every module of the unit.
`default_nettype none

package mrpi_pkg;

    localparam int NUM_SLOTS      = 4;
    localparam int MAX_STRATEGIES = 16;
    localparam int SLOT_W         = $clog2(NUM_SLOTS);
    localparam int CNT_W          = 3;
    localparam int DIGIT_W        = $clog2(MAX_STRATEGIES);
    localparam int RADIX_W        = DIGIT_W + 1;
    localparam int NUM_W          = 16;
    localparam int BITS_PER_STAGE = 2;
    localparam int CONV_STAGES    = NUM_W / BITS_PER_STAGE;
    localparam int HORNER_STAGES  = NUM_SLOTS - 1;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 5;
    localparam int REG_IDX_W      = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PLAYER_COUNT = 3'd0,
        REG_RADIX_0      = 3'd1,
        REG_RADIX_1      = 3'd2,
        REG_RADIX_2      = 3'd3,
        REG_RADIX_3      = 3'd4
    } t_reg_idx;

    typedef enum logic {
        ACT_DECODE = 1'b0,
        ACT_INSERT = 1'b1
    } t_action;

    typedef logic [RADIX_W-1:0] t_radix;
    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [SLOT_W-1:0]  t_slot;

    typedef struct packed {
        logic   carry;
        t_digit digit;
    } t_dbl;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic [NUM_W-1:0]     number;
        logic [NUM_SLOTS-1:0] pass_mask;   // slot carries no digit during conversion
        t_slot                last_slot;
        logic                 ins_valid;
        t_slot                ins_slot;
        t_digit               ins_digit;
        logic                 err;
    } t_work;

    // One binary bit shifted into one mixed-radix digit: 2*d + cin, reduced by r.
    function automatic t_dbl dbl_step(t_digit d, logic cin, t_radix r);
        t_radix sum;
        t_dbl   res;
        sum = {d, cin};
        if (sum >= r) begin
            res.carry = 1'b1;
            res.digit = DIGIT_W'(sum - r);
        end else begin
            res.carry = 1'b0;
            res.digit = DIGIT_W'(sum);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* sv/mrpi_front.sv */
// Front of the unit: accepts items, checks ranges, reduces the strategy.
// Depends on mrpi_pkg.
`default_nettype none

module mrpi_front import mrpi_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    output logic                      o_full,
    input  logic                      i_action,
    input  logic [SLOT_W-1:0]         i_player,
    input  logic [DIGIT_W-1:0]        i_strategy,
    input  logic [NUM_W-1:0]          i_number,
    input  t_radix [NUM_SLOTS-1:0]    i_eff_radix,
    input  t_slot                     i_last_slot,
    output logic                      o_work_valid,
    output t_work                     o_work,
    input  logic                      i_queue_full
);

    logic   take;
    logic   insert;
    logic   player_ok;
    logic   strat_hi;
    t_radix radix_p;
    t_digit smod;
    t_dbl   st;
    t_work  n_work;
    logic   r_valid;
    t_work  r_work;

    assign take         = !r_valid || !i_queue_full;
    assign o_full       = !take;
    assign o_work_valid = r_valid;
    assign o_work       = r_work;

    always_comb begin
        insert    = (t_action'(i_action) == ACT_INSERT);
        player_ok = (i_player <= i_last_slot);
        radix_p   = i_eff_radix[i_player];
        strat_hi  = (RADIX_W'(i_strategy) >= radix_p);
        // strategy mod radix, one bit per step
        smod = '0;
        st   = '0;
        for (int b = DIGIT_W - 1; b >= 0; b--) begin
            st   = dbl_step(smod, i_strategy[b], radix_p);
            smod = st.digit;
        end
        n_work.number    = i_number;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            n_work.pass_mask[i] = (SLOT_W'(i) > i_last_slot) ||
                                  (insert && player_ok && (i_player == SLOT_W'(i)));
        end
        n_work.last_slot = i_last_slot;
        n_work.ins_valid = insert && player_ok;
        n_work.ins_slot  = i_player;
        n_work.ins_digit = smod;
        n_work.err       = insert && (!player_ok || strat_hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_push) begin
            r_work <= n_work;
        end
    end

endmodule

`default_nettype wire

/* sv/mrpi_fifo.sv */
// Short queue of classified items between front and back.
// Depends on mrpi_pkg.
`default_nettype none

module mrpi_fifo import mrpi_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_work o_data,
    output logic  o_empty
);

    t_work             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= QPTR_W'(r_wr + 1'b1);
            end
            if (i_pop) begin
                r_rd <= QPTR_W'(r_rd + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_count <= (QPTR_W + 1)'(r_count + 1'b1);
            end else if (!i_push && i_pop) begin
                r_count <= (QPTR_W + 1)'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* sv/mrpi_back.sv */
// Back of the unit: binary to mixed-radix conversion pipeline, digit insertion,
// Horner rebuild of the profile number and the per-player result register.
// Depends on mrpi_pkg.
`default_nettype none

module mrpi_back import mrpi_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_empty,
    input  t_work                  i_q_data,
    output logic                   o_q_pop,
    input  t_radix [NUM_SLOTS-1:0] i_eff_radix,
    output logic                   o_empty,
    input  logic                   i_pop,
    output logic [NUM_W-1:0]       o_profile_index,
    output logic [SLOT_W-1:0]      o_player_slot,
    output logic [DIGIT_W-1:0]     o_strategy_digit,
    output logic                   o_last,
    output logic                   o_error
);

    localparam int PROD_W = NUM_W + RADIX_W;

    typedef struct packed {
        t_work                   w;
        t_digit [NUM_SLOTS-1:0]  digits;
        logic                    ovf;
    } t_conv;

    typedef struct packed {
        logic [NUM_W-1:0]        acc;
        t_digit [NUM_SLOTS-1:0]  digits;
        t_slot                   last_slot;
        logic                    err;
    } t_res;

    logic   adv;
    logic   ser_last;

    t_conv  cv_src       [CONV_STAGES];
    logic   cv_src_valid [CONV_STAGES];
    t_conv  n_cv         [CONV_STAGES];
    t_conv  r_cv         [CONV_STAGES];
    logic   r_cv_valid   [CONV_STAGES];

    t_res   hn_src       [HORNER_STAGES];
    logic   hn_src_valid [HORNER_STAGES];
    t_res   n_hn         [HORNER_STAGES];
    t_res   r_hn         [HORNER_STAGES];
    logic   r_hn_valid   [HORNER_STAGES];

    t_res   ins_res;
    logic   r_ser_valid;
    t_slot  r_ser_slot;
    t_res   r_ser;

    // whole pipeline moves when the result register frees up
    assign ser_last = (r_ser_slot == r_ser.last_slot);
    assign adv      = !r_ser_valid || (i_pop && ser_last);
    assign o_q_pop  = adv && !i_q_empty;

    // conversion: two number bits per stage, all digits ripple per bit
    for (genvar k = 0; k < CONV_STAGES; k++) begin : g_conv
        if (k == 0) begin : g_head
            always_comb begin
                cv_src[k].w      = i_q_data;
                cv_src[k].digits = '0;
                cv_src[k].ovf    = 1'b0;
                cv_src_valid[k]  = !i_q_empty;
            end
        end else begin : g_link
            always_comb begin
                cv_src[k]       = r_cv[k-1];
                cv_src_valid[k] = r_cv_valid[k-1];
            end
        end

        always_comb begin : cv_step
            t_conv                  x;
            t_radix [NUM_SLOTS-1:0] conv_r;
            t_dbl                   st;
            logic                   c;
            x = cv_src[k];
            for (int i = 0; i < NUM_SLOTS; i++) begin
                conv_r[i] = x.w.pass_mask[i] ? RADIX_W'(1) : i_eff_radix[i];
            end
            for (int b = 0; b < BITS_PER_STAGE; b++) begin
                c = x.w.number[NUM_W - 1 - k * BITS_PER_STAGE - b];
                for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
                    st          = dbl_step(x.digits[i], c, conv_r[i]);
                    x.digits[i] = st.digit;
                    c           = st.carry;
                end
                x.ovf = x.ovf | c;
            end
            n_cv[k] = x;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv_valid[k] <= 1'b0;
            end else if (adv) begin
                r_cv_valid[k] <= cv_src_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_cv[k] <= n_cv[k];
            end
        end
    end

    // drop the inserted strategy into its slot and seed the accumulator
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (r_cv[CONV_STAGES-1].w.ins_valid &&
                (r_cv[CONV_STAGES-1].w.ins_slot == SLOT_W'(i))) begin
                ins_res.digits[i] = r_cv[CONV_STAGES-1].w.ins_digit;
            end else begin
                ins_res.digits[i] = r_cv[CONV_STAGES-1].digits[i];
            end
        end
        ins_res.acc       = NUM_W'(ins_res.digits[0]);
        ins_res.last_slot = r_cv[CONV_STAGES-1].w.last_slot;
        ins_res.err       = r_cv[CONV_STAGES-1].w.err | r_cv[CONV_STAGES-1].ovf;
    end

    // Horner rebuild: one multiply-add per stage
    for (genvar h = 0; h < HORNER_STAGES; h++) begin : g_horner
        if (h == 0) begin : g_head
            always_comb begin
                hn_src[h]       = ins_res;
                hn_src_valid[h] = r_cv_valid[CONV_STAGES-1];
            end
        end else begin : g_link
            always_comb begin
                hn_src[h]       = r_hn[h-1];
                hn_src_valid[h] = r_hn_valid[h-1];
            end
        end

        always_comb begin : hn_step
            t_res              x;
            t_radix            rad;
            logic [PROD_W-1:0] prod;
            x    = hn_src[h];
            rad  = (SLOT_W'(h + 1) <= x.last_slot) ? i_eff_radix[h+1] : RADIX_W'(1);
            prod = PROD_W'(x.acc) * PROD_W'(rad);
            x.acc = NUM_W'(prod + PROD_W'(x.digits[h+1]));
            n_hn[h] = x;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_hn_valid[h] <= 1'b0;
            end else if (adv) begin
                r_hn_valid[h] <= hn_src_valid[h];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_hn[h] <= n_hn[h];
            end
        end
    end

    // result register: walk the slots, one transaction per active player
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_valid <= 1'b0;
            r_ser_slot  <= '0;
        end else if (adv) begin
            r_ser_valid <= r_hn_valid[HORNER_STAGES-1];
            r_ser_slot  <= '0;
        end else if (i_pop) begin
            r_ser_slot  <= SLOT_W'(r_ser_slot + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ser <= r_hn[HORNER_STAGES-1];
        end
    end

    assign o_empty          = !r_ser_valid;
    assign o_profile_index  = r_ser.acc;
    assign o_player_slot    = r_ser_slot;
    assign o_strategy_digit = r_ser.digits[r_ser_slot];
    assign o_last           = ser_last;
    assign o_error          = r_ser.err;

endmodule

`default_nettype wire

/* sv/mixed_radix_profile_index_unit.sv */
// Top level of the mixed-radix profile index unit: configuration registers,
// front, item queue and back. Depends on mrpi_pkg, mrpi_front, mrpi_fifo,
// mrpi_back and mixed_radix_profile_index_unit_assert.svh.
//
//   channel   | handshake              | payload
//   ----------+------------------------+---------------------------------------------
//   config    | psel/penable/pwrite    | paddr, pwdata, prdata (pready tied high)
//   items in  | push, full             | i_action, i_player, i_strategy, i_number
//   results   | empty, pop             | o_profile_index, o_player_slot,
//             |                        | o_strategy_digit, o_last, o_error
//
// Each item yields one result per active player (1 to 4), one result per cycle
// while pop is held; new items enter while earlier ones are still in flight. An
// item passes, in order, through the front register, the queue, eight conversion
// stages, three multiply-add stages and the result register.
// Reset is synchronous, active low; it sets player_count and the radices to 1
// and empties every stage. No clearing pass follows reset.
// A stalled result holds the whole back pipeline; the queue and the front keep
// taking items until both are full.
`default_nettype none

`include "mixed_radix_profile_index_unit_assert.svh"

module mixed_radix_profile_index_unit import mrpi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // item channel
    input  logic                  push,
    output logic                  full,
    input  logic                  i_action,
    input  logic [SLOT_W-1:0]     i_player,
    input  logic [DIGIT_W-1:0]    i_strategy,
    input  logic [NUM_W-1:0]      i_number,
    // result channel
    output logic                  empty,
    input  logic                  pop,
    output logic [NUM_W-1:0]      o_profile_index,
    output logic [SLOT_W-1:0]     o_player_slot,
    output logic [DIGIT_W-1:0]    o_strategy_digit,
    output logic                  o_last,
    output logic                  o_error
);

    logic [CNT_W-1:0]       r_player_count;
    t_radix [NUM_SLOTS-1:0] r_radix;

    t_reg_idx               reg_idx;
    logic                   cfg_write;
    t_radix [NUM_SLOTS-1:0] w_eff_radix;
    t_slot                  w_last_slot;

    logic                   w_front_valid;
    t_work                  w_front_work;
    logic                   w_q_full;
    logic                   w_q_empty;
    logic                   w_q_pop;
    t_work                  w_q_data;

    // ---------------------------------------------------------------------
    // Configuration: write on the access phase, read back raw register values
    // ---------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_player_count <= CNT_W'(1);
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_radix[i] <= RADIX_W'(1);
            end
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_PLAYER_COUNT: r_player_count <= pwdata[CNT_W-1:0];
                REG_RADIX_0:      r_radix[0]     <= pwdata[RADIX_W-1:0];
                REG_RADIX_1:      r_radix[1]     <= pwdata[RADIX_W-1:0];
                REG_RADIX_2:      r_radix[2]     <= pwdata[RADIX_W-1:0];
                REG_RADIX_3:      r_radix[3]     <= pwdata[RADIX_W-1:0];
                default: begin
                    // addresses past the register list: drop the write
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PLAYER_COUNT: prdata = APB_DATA_W'(r_player_count);
            REG_RADIX_0:      prdata = APB_DATA_W'(r_radix[0]);
            REG_RADIX_1:      prdata = APB_DATA_W'(r_radix[1]);
            REG_RADIX_2:      prdata = APB_DATA_W'(r_radix[2]);
            REG_RADIX_3:      prdata = APB_DATA_W'(r_radix[3]);
            default:          prdata = '0;
        endcase
    end

    // Clamp the raw settings: a zero radix or count acts as one, and values
    // past the supported range act as the limit.
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (r_radix[i] == '0) begin
                w_eff_radix[i] = RADIX_W'(1);
            end else if (r_radix[i] > RADIX_W'(MAX_STRATEGIES)) begin
                w_eff_radix[i] = RADIX_W'(MAX_STRATEGIES);
            end else begin
                w_eff_radix[i] = r_radix[i];
            end
        end
        if (r_player_count == '0) begin
            w_last_slot = '0;
        end else if (r_player_count > CNT_W'(NUM_SLOTS)) begin
            w_last_slot = SLOT_W'(NUM_SLOTS - 1);
        end else begin
            w_last_slot = SLOT_W'(r_player_count - CNT_W'(1));
        end
    end

    // ---------------------------------------------------------------------
    // Front: take the transaction, range-check it and reduce the strategy
    // ---------------------------------------------------------------------
    mrpi_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_action     (i_action),
        .i_player     (i_player),
        .i_strategy   (i_strategy),
        .i_number     (i_number),
        .i_eff_radix  (w_eff_radix),
        .i_last_slot  (w_last_slot),
        .o_work_valid (w_front_valid),
        .o_work       (w_front_work),
        .i_queue_full (w_q_full)
    );

    // Queue: lets the front keep accepting while the back waits on pop
    mrpi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid && !w_q_full),
        .i_data  (w_front_work),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_data),
        .o_empty (w_q_empty)
    );

    // Back: convert, insert, rebuild the profile number, emit per player
    mrpi_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (w_q_empty),
        .i_q_data         (w_q_data),
        .o_q_pop          (w_q_pop),
        .i_eff_radix      (w_eff_radix),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_profile_index  (o_profile_index),
        .o_player_slot    (o_player_slot),
        .o_strategy_digit (o_strategy_digit),
        .o_last           (o_last),
        .o_error          (o_error)
    );

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // The final result of an item sits exactly at the last active player.
    `MRPI_ASSERT_NOW(a_last_at_final_slot, i_clk, i_rst_n, !empty,
        o_last == (o_player_slot == w_last_slot), "last flag off the final player")

    // Every digit shown stays below its player's radix.
    `MRPI_ASSERT_NOW(a_digit_in_radix, i_clk, i_rst_n, !empty,
        RADIX_W'(o_strategy_digit) < w_eff_radix[o_player_slot], "digit not below radix")

    // Taking a non-final result advances to the next player of the same item.
    `MRPI_ASSERT_NEXT(a_slot_advances, i_clk, i_rst_n, pop && !empty && !o_last,
        !empty && (o_player_slot == SLOT_W'($past(o_player_slot) + 1'b1)),
        "result walk skipped a player")

    // Profile number and error flag hold across the results of one item.
    `MRPI_ASSERT_NEXT(a_item_fields_hold, i_clk, i_rst_n, pop && !empty && !o_last,
        (o_profile_index == $past(o_profile_index)) && (o_error == $past(o_error)),
        "item fields changed between its results")

endmodule

`default_nettype wire
